// ----- rtl/fbpa_pkg.sv -----
`default_nettype none

package fbpa_pkg;

   localparam int CMD_W      = 2;
   localparam int OFS_W      = 20;
   localparam int STATUS_W   = 2;
   localparam int IDX_W      = 8;
   localparam int CNT_W      = 9;
   localparam int SIZE_W     = 13;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAN = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_SIZE  = 4'd1;

   localparam logic [CNT_W-1:0]  COUNT_RESET = 9'd256;
   localparam logic [SIZE_W-1:0] SIZE_RESET  = 13'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } fsm_state_type;

endpackage

`default_nettype wire

// ----- rtl/fbpa_if.sv -----
`default_nettype none

interface fbpa_req_if;
   import fbpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [OFS_W-1:0]    node_offset;
   modport source (output valid, command, node_offset, input ready);
   modport sink   (input valid, command, node_offset, output ready);
endinterface

interface fbpa_rsp_if;
   import fbpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    node_index;
   logic [OFS_W-1:0]    alloc_offset;
   logic [CNT_W-1:0]    free_nodes;
   modport source (output valid, status, node_index, alloc_offset, free_nodes, input ready);
   modport sink   (input valid, status, node_index, alloc_offset, free_nodes, output ready);
endinterface

interface fbpa_csr_if;
   import fbpa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fbpa_ram.sv -----
`default_nettype none

module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fbpa_div.sv -----
`default_nettype none

module fbpa_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [fbpa_pkg::OFS_W-1:0]    dividend,
   input  wire logic [fbpa_pkg::SIZE_W-1:0]   divisor,
   output logic                               done,
   output logic      [fbpa_pkg::OFS_W-1:0]    quotient
);
   import fbpa_pkg::*;

   localparam int CW = $clog2(OFS_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [OFS_W-1:0]  quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] dsr_ff, dsr_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, quo_ff[OFS_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[OFS_W-2:0], ge};
         rem_in = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(OFS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator. Allocate pops a free node index (LIFO, fresh nodes
// handed out in order 0, 1, 2, ... once the freed stack is empty) and answers with its
// byte offset; free divides the offset by the node size and pushes the index unless it
// is rejected; clean returns every node. Freed indices live in a one-port-read,
// one-port-write RAM that needs no clearing pass after reset. One item is in work at a
// time, while the previous result may still sit in the output register. An allocate
// from the freed stack reads the RAM, then does the offset multiply; one from a fresh
// node does the multiply alone; clean and no-op go straight to the result. A free runs
// the bit-serial divider, one quotient bit per cycle over the 20-bit offset. Writes to the
// count or size register also clean the pool, and writes are taken in any cycle.
`default_nettype none

module fixed_block_pool_allocator #(
   parameter int MAX_NODES      = 256,
   parameter int MAX_NODE_BYTES = 4096
) (
   input  wire logic clock,
   input  wire logic reset,
   fbpa_req_if.sink  req_ch,
   fbpa_rsp_if.source rsp_ch,
   fbpa_csr_if.sink  csr_ch
);
   import fbpa_pkg::*;

   localparam int CNT_CAP = (MAX_NODES > 511) ? 511 : MAX_NODES;
   localparam int SZ_CAP  = (MAX_NODE_BYTES > 8191) ? 8191 : MAX_NODE_BYTES;
   localparam int AW      = $clog2(MAX_NODES);
   localparam int DW      = $clog2(MAX_NODES + 1);
   localparam int FW      = $clog2(CNT_CAP + 1);
   localparam int SW      = $clog2(CNT_CAP);
   localparam int TW      = ((DW > CNT_W) ? DW : CNT_W) + 1;
   localparam int PW      = (SW + SIZE_W > OFS_W) ? SW + SIZE_W : OFS_W;

   fsm_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   node_count_ff, node_count_in;
   logic [SIZE_W-1:0]  node_size_ff, node_size_in;
   logic [DW-1:0]      depth_ff, depth_in;
   logic [FW-1:0]      fresh_ff, fresh_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic [OFS_W-1:0]   res_ofs_ff, res_ofs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [OFS_W-1:0]   rsp_ofs_ff, rsp_ofs_in;
   logic [CNT_W-1:0]   rsp_free_ff, rsp_free_in;

   logic [CNT_W-1:0]   eff_cnt;
   logic [SIZE_W-1:0]  eff_size;
   logic [CNT_W-1:0]   fresh_ext;
   logic               fresh_avail;
   logic [CNT_W-1:0]   fresh_left;
   logic [TW-1:0]      free_total;
   logic [DW-1:0]      depth_m1;
   logic               req_fire;
   logic               csr_fire;
   logic               out_load;
   logic               div_start;
   logic               div_done;
   logic [OFS_W-1:0]   quotient;
   logic               reject;
   logic [PW-1:0]      prod;
   logic [PW-1:0]      idx_wide;
   logic               ram_we;
   logic               ram_re;
   logic [SW-1:0]      ram_rdata;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign eff_cnt  = (node_count_ff == '0) ? CNT_W'(1) :
                     (node_count_ff > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : node_count_ff;
   assign eff_size = (node_size_ff == '0) ? SIZE_W'(1) :
                     (node_size_ff > SIZE_W'(SZ_CAP)) ? SIZE_W'(SZ_CAP) : node_size_ff;

   assign fresh_ext   = CNT_W'(fresh_ff);
   assign fresh_avail = fresh_ext < eff_cnt;
   assign fresh_left  = fresh_avail ? (eff_cnt - fresh_ext) : '0;
   assign free_total  = TW'(depth_ff) + TW'(fresh_left);
   assign depth_m1    = depth_ff - DW'(1);

   assign reject = (quotient >= OFS_W'(eff_cnt)) || (free_total >= TW'(eff_cnt)) ||
                   (depth_ff >= DW'(MAX_NODES));

   assign idx_wide = PW'(idx_ff);
   assign prod     = PW'(idx_ff) * PW'(eff_size);

   assign div_start = req_fire && (command_type'(req_ch.command) == CMD_FREE);
   assign ram_re    = req_fire && (command_type'(req_ch.command) == CMD_ALLOC) &&
                      (depth_ff != '0);
   assign ram_we    = (state_ff == ST_DIV) && div_done && !reject;

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ch.node_offset),
      .divisor  (eff_size),
      .done     (div_done),
      .quotient (quotient)
   );

   fbpa_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_NODES)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (quotient[SW-1:0]),
      .rd_en   (ram_re),
      .rd_addr (depth_m1[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (command_type'(req_ch.command))
                  CMD_ALLOC: begin
                     if (depth_ff != '0) begin
                        state_in = ST_POP;
                     end else if (fresh_avail) begin
                        state_in = ST_MUL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  CMD_FREE: state_in = ST_DIV;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_POP: state_in = ST_MUL;
         ST_MUL: state_in = ST_DONE;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      node_count_in = node_count_ff;
      node_size_in  = node_size_ff;
      depth_in      = depth_ff;
      fresh_in      = fresh_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_ofs_in    = res_ofs_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_ofs_in    = rsp_ofs_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_status_in = STATUS_OK;
               res_idx_in    = '0;
               res_ofs_in    = '0;
               case (command_type'(req_ch.command))
                  CMD_ALLOC: begin
                     if (depth_ff != '0) begin
                        depth_in = depth_m1;
                     end else if (fresh_avail) begin
                        idx_in   = SW'(fresh_ff);
                        fresh_in = fresh_ff + FW'(1);
                     end else begin
                        res_status_in = STATUS_EMPTY;
                     end
                  end
                  CMD_CLEAN: begin
                     depth_in = '0;
                     fresh_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: idx_in = ram_rdata;
         ST_MUL: begin
            res_idx_in = idx_wide[IDX_W-1:0];
            res_ofs_in = prod[OFS_W-1:0];
         end
         ST_DIV: begin
            if (div_done) begin
               if (reject) begin
                  res_status_in = STATUS_REJECT;
               end else begin
                  res_idx_in = quotient[IDX_W-1:0];
                  depth_in   = depth_ff + DW'(1);
               end
            end
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_ofs_in    = res_ofs_ff;
               rsp_free_in   = free_total[CNT_W-1:0];
            end
         end
         default: ;
      endcase

      // writes to the count and size registers also clean the pool
      if (csr_fire) begin
         if (csr_ch.index == REG_NODE_COUNT) begin
            node_count_in = csr_ch.data[CNT_W-1:0];
            depth_in      = '0;
            fresh_in      = '0;
         end else if (csr_ch.index == REG_NODE_SIZE) begin
            node_size_in = csr_ch.data[SIZE_W-1:0];
            depth_in     = '0;
            fresh_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= COUNT_RESET;
         node_size_ff  <= SIZE_RESET;
         depth_ff      <= '0;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         node_size_ff  <= node_size_in;
         depth_ff      <= depth_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_ofs_ff    <= res_ofs_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_ofs_ff    <= rsp_ofs_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.node_index   = rsp_idx_ff;
   assign rsp_ch.alloc_offset = rsp_ofs_ff;
   assign rsp_ch.free_nodes   = rsp_free_ff;

   a_free_le_cnt: assert property (@(posedge clock) disable iff (reset)
      free_total <= TW'(eff_cnt))
      else $error("free node count exceeds pool size");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside a free");

   a_pop_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> $past(ram_re))
      else $error("stack read state without a stack read");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !csr_fire) |=> (depth_ff == $past(depth_ff) + DW'(1)))
      else $error("push did not grow the freed stack");

endmodule

`default_nettype wire

// ----- dv/tb_fixed_block_pool_allocator.sv -----
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
   import fbpa_pkg::*;

   localparam int POOL_DEPTH  = 256;
   localparam int SIZE_CAP    = 4096;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 85;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 4'd15;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    node_index;
      logic [OFS_W-1:0]    alloc_offset;
      logic [CNT_W-1:0]    free_nodes;
   } pool_answer_type;

   typedef struct {
      bit                    is_write;
      logic [CSR_IDX_W-1:0]  reg_sel;
      logic [CSR_DATA_W-1:0] reg_val;
      command_type           cmd;
      logic [OFS_W-1:0]      ofs;
      bit                    typed;
      pool_answer_type       want;
   } plan_row_type;

   logic clock;
   logic reset;

   fbpa_req_if req_ch();
   fbpa_rsp_if rsp_ch();
   fbpa_csr_if csr_ch();

   fixed_block_pool_allocator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // pool image: freed indices stacked above a fresh counter
   logic [IDX_W-1:0]  freed_ids [POOL_DEPTH];
   int unsigned       freed_top;
   int unsigned       fresh_next;
   logic [CNT_W-1:0]  count_reg;
   logic [SIZE_W-1:0] size_reg;

   pool_answer_type   expected_answers [$];
   logic [OFS_W-1:0]  held_offsets [$];
   plan_row_type      plan [$];
   int unsigned       mismatches = 0;
   bit                quiet = 1'b0;
   bit                hold_req = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int unsigned pool_count();
      if (count_reg == '0) return 1;
      if (count_reg > POOL_DEPTH) return POOL_DEPTH;
      return 32'(count_reg);
   endfunction

   function automatic int unsigned pool_size();
      if (size_reg == '0) return 1;
      if (size_reg > SIZE_CAP) return SIZE_CAP;
      return 32'(size_reg);
   endfunction

   function automatic int unsigned pool_free();
      int unsigned cnt;
      cnt = pool_count();
      return freed_top + ((fresh_next < cnt) ? cnt - fresh_next : 0);
   endfunction

   function automatic void pool_clean();
      freed_top = 0;
      fresh_next = 0;
      held_offsets.delete();
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] sel, logic [CSR_DATA_W-1:0] val);
      if (sel == REG_NODE_COUNT) begin
         count_reg = val[CNT_W-1:0];
         pool_clean();
      end else if (sel == REG_NODE_SIZE) begin
         size_reg = val[SIZE_W-1:0];
         pool_clean();
      end
   endfunction

   function automatic pool_answer_type pool_predict(command_type cmd, logic [OFS_W-1:0] ofs);
      pool_answer_type ans;
      int unsigned  cnt;
      int unsigned  sz;
      int unsigned  idx;
      bit           got;
      cnt = pool_count();
      sz = pool_size();
      ans = '0;
      ans.status = STATUS_OK;
      idx = 0;
      case (cmd)
         CMD_ALLOC: begin
            got = 1'b1;
            if (freed_top > 0) begin
               freed_top--;
               idx = 32'(freed_ids[freed_top]);
            end else if (fresh_next < cnt) begin
               idx = fresh_next;
               fresh_next++;
            end else begin
               got = 1'b0;
            end
            if (got) begin
               ans.node_index = IDX_W'(idx);
               ans.alloc_offset = OFS_W'(idx * sz);
               held_offsets.push_back(ans.alloc_offset);
            end else begin
               ans.status = STATUS_EMPTY;
            end
         end
         CMD_FREE: begin
            idx = ofs / sz;
            if (idx >= cnt || pool_free() >= cnt || freed_top >= POOL_DEPTH) begin
               ans.status = STATUS_REJECT;
            end else begin
               freed_ids[freed_top] = IDX_W'(idx);
               freed_top++;
               ans.node_index = IDX_W'(idx);
               for (int i = 0; i < held_offsets.size(); i++) begin
                  if (held_offsets[i] / sz == idx) begin
                     held_offsets.delete(i);
                     break;
                  end
               end
            end
         end
         CMD_CLEAN: pool_clean();
         default: ;
      endcase
      ans.free_nodes = CNT_W'(pool_free());
      return ans;
   endfunction

   function automatic plan_row_type blank_row();
      plan_row_type row;
      row.is_write = 1'b0;
      row.reg_sel = '0;
      row.reg_val = '0;
      row.cmd = CMD_NOP;
      row.ofs = '0;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic void plan_item(command_type cmd, logic [OFS_W-1:0] ofs);
      plan_row_type row;
      row = blank_row();
      row.cmd = cmd;
      row.ofs = ofs;
      plan.push_back(row);
   endfunction

   function automatic void plan_check(command_type cmd, logic [OFS_W-1:0] ofs,
                                      logic [STATUS_W-1:0] status, logic [IDX_W-1:0] idx,
                                      logic [OFS_W-1:0] aofs, logic [CNT_W-1:0] free_n);
      plan_row_type row;
      row = blank_row();
      row.cmd = cmd;
      row.ofs = ofs;
      row.typed = 1'b1;
      row.want = '{status, idx, aofs, free_n};
      plan.push_back(row);
   endfunction

   function automatic void plan_write(logic [CSR_IDX_W-1:0] sel, logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = blank_row();
      row.is_write = 1'b1;
      row.reg_sel = sel;
      row.reg_val = val;
      row.cmd = CMD_NOP;
      plan.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic send_item(input command_type cmd, input logic [OFS_W-1:0] ofs,
                            input bit typed, input pool_answer_type want);
      pool_answer_type ans;
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.node_offset <= ofs;
      do @(posedge clock); while (!req_ch.ready);
      ans = pool_predict(cmd, ofs);
      expected_answers.push_back(typed ? want : ans);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] sel, input logic [CSR_DATA_W-1:0] val);
      req_ch.valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= sel;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      apply_reg(sel, val);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         if (hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pool_answer_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("result with no item pending, free_nodes",
                            32'(rsp_ch.free_nodes), 0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            if (rsp_ch.node_index !== want.node_index)
               report_mismatch("node_index", 32'(rsp_ch.node_index), 32'(want.node_index));
            if (rsp_ch.alloc_offset !== want.alloc_offset)
               report_mismatch("alloc_offset", 32'(rsp_ch.alloc_offset),
                               32'(want.alloc_offset));
            if (rsp_ch.free_nodes !== want.free_nodes)
               report_mismatch("free_nodes", 32'(rsp_ch.free_nodes), 32'(want.free_nodes));
         end
      end
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int unsigned           bias;
      int unsigned           run_left;
      int unsigned           cnt;
      int unsigned           sz;
      int unsigned           r;
      int unsigned           waited;
      logic [CSR_DATA_W-1:0] cnt_val;
      logic [CSR_DATA_W-1:0] sz_val;
      logic [OFS_W-1:0]      ofs;
      command_type           cmd;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_NOP;
      req_ch.node_offset <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      count_reg = COUNT_RESET;
      size_reg = SIZE_RESET;
      pool_clean();

      // reset config: 256 nodes of 64 bytes
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd0,   20'd0,       9'd255);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd1,   20'd64,      9'd254);
      plan_check(CMD_FREE,  20'd64,     STATUS_OK,     8'd1,   20'd0,       9'd255);
      // unaligned double free still pushes
      plan_check(CMD_FREE,  20'd65,     STATUS_OK,     8'd1,   20'd0,       9'd256);
      plan_check(CMD_FREE,  20'd0,      STATUS_REJECT, 8'd0,   20'd0,       9'd256);
      plan_check(CMD_FREE,  20'hFFFFF,  STATUS_REJECT, 8'd0,   20'd0,       9'd256);
      plan_check(CMD_ALLOC, 20'hFFFFF,  STATUS_OK,     8'd1,   20'd64,      9'd255);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd1,   20'd64,      9'd254);
      plan_check(CMD_NOP,   20'hFFFFF,  STATUS_OK,     8'd0,   20'd0,       9'd254);
      plan_check(CMD_CLEAN, 20'hFFFFF,  STATUS_OK,     8'd0,   20'd0,       9'd256);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd0,   20'd0,       9'd255);
      plan_check(CMD_FREE,  20'd16383,  STATUS_OK,     8'd255, 20'd0,       9'd256);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd255, 20'd16320,   9'd255);
      // zero registers clamp to one node of one byte
      plan_write(REG_NODE_COUNT, 13'd0);
      plan_write(REG_NODE_SIZE,  13'd0);
      plan_check(CMD_FREE,  20'd0,      STATUS_REJECT, 8'd0,   20'd0,       9'd1);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd0,   20'd0,       9'd0);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_EMPTY,  8'd0,   20'd0,       9'd0);
      plan_check(CMD_FREE,  20'd1,      STATUS_REJECT, 8'd0,   20'd0,       9'd0);
      plan_check(CMD_FREE,  20'd0,      STATUS_OK,     8'd0,   20'd0,       9'd1);
      // oversized registers clamp to 256 nodes of 4096 bytes
      plan_write(REG_NODE_COUNT, 13'd511);
      plan_write(REG_NODE_SIZE,  13'd8191);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd0,   20'd0,       9'd255);
      plan_check(CMD_FREE,  20'hFFFFF,  STATUS_OK,     8'd255, 20'd0,       9'd256);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd255, 20'd1044480, 9'd255);
      plan_check(CMD_ALLOC, 20'd0,      STATUS_OK,     8'd1,   20'd4096,    9'd254);
      // unused register index leaves the pool alone
      plan_write(REG_SPARE, 13'd3);
      plan_item(CMD_ALLOC, 20'd0);
      plan_item(CMD_FREE,  20'd8192);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write)
            write_reg(plan[i].reg_sel, plan[i].reg_val);
         else
            send_item(plan[i].cmd, plan[i].ofs, plan[i].typed, plan[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin cnt_val = 13'd4;   sz_val = 13'd64;   end
            1: begin cnt_val = 13'd1;   sz_val = 13'd1;    end
            2: begin cnt_val = 13'd256; sz_val = 13'd4096; end
            3: begin cnt_val = 13'd16;  sz_val = 13'd3;    end
            4: begin cnt_val = 13'd2;   sz_val = 13'd4096; end
            5: begin
               cnt_val = {4'($urandom_range(0, 15)), 9'($urandom_range(1, 40))};
               sz_val = 13'($urandom_range(1, 4096));
            end
            6: begin
               cnt_val = 13'($urandom_range(1, 256));
               sz_val = 13'($urandom_range(1, 300));
            end
            default: begin cnt_val = 13'd8; sz_val = 13'd1; end
         endcase
         write_reg(REG_NODE_COUNT, cnt_val);
         write_reg(REG_NODE_SIZE, sz_val);
         quiet = (ph == PHASES - 1);
         run_left = 0;
         bias = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == 20) hold_req = 1'b1;
            // swing between filling and draining the pool
            if (run_left == 0) begin
               case ($urandom_range(0, 2))
                  0: bias = 15;
                  1: bias = 50;
                  default: bias = 85;
               endcase
               run_left = $urandom_range(8, 30);
            end
            run_left--;
            cnt = pool_count();
            sz = pool_size();
            ofs = OFS_W'($urandom());
            r = $urandom_range(0, 99);
            if (r < 3) begin
               cmd = CMD_CLEAN;
            end else if (r < 6) begin
               cmd = CMD_NOP;
            end else if ($urandom_range(0, 99) < bias) begin
               cmd = CMD_ALLOC;
            end else begin
               cmd = CMD_FREE;
               r = $urandom_range(0, 99);
               if (r < 60 && held_offsets.size() > 0) begin
                  ofs = held_offsets[$urandom_range(0, held_offsets.size() - 1)];
                  if ($urandom_range(0, 3) == 0) ofs = ofs + OFS_W'($urandom_range(0, sz - 1));
               end else if (r < 80) begin
                  ofs = OFS_W'($urandom_range(0, cnt - 1) * sz + $urandom_range(0, sz - 1));
               end else if (r < 90 && cnt * sz <= 20'hFFFFF) begin
                  ofs = OFS_W'($urandom_range(cnt * sz, 20'hFFFFF));
               end
            end
            send_item(cmd, ofs, 1'b0, '0);
         end
      end
      req_ch.valid <= 1'b0;

      waited = 0;
      while (expected_answers.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      foreach (expected_answers[i])
         report_mismatch("missing result, free_nodes", 0, 32'(expected_answers[i].free_nodes));

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
